@@ hdl/b85_pkg.sv @@
// b85_pkg: shared constants and the group record of the base-85 encoder.
// No dependencies; used by every module under hdl.
`default_nettype none

package b85_pkg;

    localparam int unsigned DIGIT_W  = 7;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned QUOT_W   = 26;  // widest quotient of a 32-bit word over 85
    localparam int unsigned NCHR_W   = 3;
    localparam int unsigned DIGS     = 4;   // low-order digits carried down the divider
    localparam int unsigned CHARS    = 5;

    localparam logic [DIGIT_W-1:0] CHAR_OFFSET = 7'd33;
    localparam logic [DIGIT_W-1:0] CHAR_MIN    = 7'd33;
    localparam logic [DIGIT_W-1:0] CHAR_MAX    = 7'd117;

    // floor(x / 85) == (x * RECIP) >> RECIP_SHIFT for every 32-bit x
    localparam logic [WORD_W-1:0] RECIP       = 32'd3233857729;
    localparam int unsigned       RECIP_SHIFT = 38;

    typedef logic [DIGIT_W-1:0] t_digit;

    typedef struct packed {
        logic [WORD_W-1:0]         quot;
        logic [DIGS-1:0][DIGIT_W-1:0] digs;   // digs[0] is the least significant digit
        logic [NCHR_W-1:0]         nchr;      // characters to emit, 2..5
        logic                      msg_end;
    } t_grp;

endpackage

`default_nettype wire

@@ hdl/b85_pack.sv @@
// b85_pack: collects input bytes into big-endian groups of up to four.
// Depends on b85_pkg; feeds the first b85_div_stage.
`default_nettype none

module b85_pack (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_vld,
    output logic                 o_rdy,
    input  wire  [7:0]           i_byte,
    input  wire                  i_last,
    output logic                 o_vld,
    input  wire                  i_rdy,
    output b85_pkg::t_grp        o_grp
);

    logic [23:0]          r_held;
    logic [1:0]           r_cnt;
    logic                 r_vld;
    b85_pkg::t_grp        r_grp;

    logic                 w_acc;
    logic                 w_done;
    logic [31:0]          w_packed;
    logic [31:0]          w_word;
    logic                 n_vld;

    assign o_rdy    = !r_vld || i_rdy;
    assign w_acc    = i_vld && o_rdy;
    assign w_done   = i_last || (r_cnt == 2'd3);
    assign w_packed = {r_held, i_byte};

    always_comb begin
        case (r_cnt)
            2'd0:    w_word = {w_packed[7:0], 24'd0};
            2'd1:    w_word = {w_packed[15:0], 16'd0};
            2'd2:    w_word = {w_packed[23:0], 8'd0};
            default: w_word = w_packed;
        endcase
    end

    always_comb begin
        n_vld = r_vld && !i_rdy;
        if (w_acc && w_done) begin
            n_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_cnt  <= '0;
            r_vld  <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (w_acc) begin
                if (w_done) begin
                    r_held <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_held <= w_packed[23:0];
                    r_cnt  <= r_cnt + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_done) begin
            r_grp.quot    <= w_word;
            r_grp.digs    <= '0;
            r_grp.nchr    <= {1'b0, r_cnt} + 3'd2;
            r_grp.msg_end <= i_last;
        end
    end

    assign o_vld = r_vld;
    assign o_grp = r_grp;

endmodule

`default_nettype wire

@@ hdl/b85_div_stage.sv @@
// b85_div_stage: one divide-by-85 step, reciprocal multiply then remainder.
// Depends on b85_pkg; four instances are chained in the top level.
`default_nettype none

module b85_div_stage (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_vld,
    output logic                 o_rdy,
    input  b85_pkg::t_grp        i_grp,
    output logic                 o_vld,
    input  wire                  i_rdy,
    output b85_pkg::t_grp        o_grp
);

    logic                           r_a_vld;
    b85_pkg::t_grp                  r_a;
    logic                           r_b_vld;
    b85_pkg::t_grp                  r_b;
    logic [b85_pkg::QUOT_W-1:0]     r_b_q;

    logic                           w_a_rdy;
    logic                           w_b_rdy;
    logic [2*b85_pkg::WORD_W-1:0]   w_prod;
    logic [b85_pkg::DIGIT_W-1:0]    w_q85;
    b85_pkg::t_digit                w_rem;

    assign w_b_rdy = !r_b_vld || i_rdy;
    assign w_a_rdy = !r_a_vld || w_b_rdy;
    assign o_rdy   = w_a_rdy;

    assign w_prod = 64'(r_a.quot) * 64'(b85_pkg::RECIP);

    // remainder < 85 fits in 7 bits, so only the low bits of q*85 matter
    assign w_q85 = 7'({r_b_q[0], 6'd0}) + 7'({r_b_q[2:0], 4'd0})
                 + 7'({r_b_q[4:0], 2'd0}) + r_b_q[6:0];
    assign w_rem = r_b.quot[6:0] - w_q85;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (w_a_rdy) begin
                r_a_vld <= i_vld;
            end
            if (w_b_rdy) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_rdy) begin
            r_a <= i_grp;
        end
        if (w_b_rdy) begin
            r_b   <= r_a;
            r_b_q <= w_prod[b85_pkg::RECIP_SHIFT +: b85_pkg::QUOT_W];
        end
    end

    always_comb begin
        o_grp         = r_b;
        o_grp.quot    = 32'(r_b_q);
        o_grp.digs    = {w_rem, r_b.digs[3:1]};
    end

    assign o_vld = r_b_vld;

endmodule

`default_nettype wire

@@ hdl/b85_serial.sv @@
// b85_serial: output register that emits a group's characters one per transfer.
// Depends on b85_pkg; fed by the last b85_div_stage.
`default_nettype none

module b85_serial (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_vld,
    output logic                 o_rdy,
    input  b85_pkg::t_grp        i_grp,
    output logic                 o_vld,
    input  wire                  i_rdy,
    output b85_pkg::t_digit      o_char,
    output logic                 o_run_end,
    output logic                 o_msg_end
);

    logic [b85_pkg::CHARS-1:0][b85_pkg::DIGIT_W-1:0] r_sh;
    logic [b85_pkg::NCHR_W-1:0]                      r_left;
    logic                                            r_msg_end;

    logic w_xfer;
    logic w_load;
    logic w_tail;

    assign w_tail = (r_left == 3'd1);
    assign w_xfer = o_vld && i_rdy;
    assign o_rdy  = (r_left == 3'd0) || (w_xfer && w_tail);
    assign w_load = i_vld && o_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (w_load) begin
            r_left <= i_grp.nchr;
        end else if (w_xfer) begin
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sh      <= {i_grp.digs[0], i_grp.digs[1], i_grp.digs[2], i_grp.digs[3],
                          i_grp.quot[6:0]};
            r_msg_end <= i_grp.msg_end;
        end else if (w_xfer) begin
            r_sh <= {7'd0, r_sh[4:1]};
        end
    end

    assign o_vld     = (r_left != 3'd0);
    assign o_char    = r_sh[0] + b85_pkg::CHAR_OFFSET;
    assign o_run_end = w_tail;
    assign o_msg_end = w_tail && r_msg_end;

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 3'd5)
        else $error("character count out of range");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_left >= 3'd2))
        else $error("group loaded with fewer than two characters");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_xfer && !w_tail) |=> (r_left == $past(r_left) - 3'd1))
        else $error("character count did not step down");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> ((o_char >= b85_pkg::CHAR_MIN) && (o_char <= b85_pkg::CHAR_MAX)))
        else $error("character outside base-85 alphabet");

    a_end_nest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vld && o_msg_end) |-> o_run_end)
        else $error("message end without run end");

endmodule

`default_nettype wire

@@ hdl/base85_stream_encoder.sv @@
// base85_stream_encoder: streaming base-85 encoder, top level.
// Depends on b85_pkg, b85_pack, b85_div_stage and b85_serial.
//
// Usage:
//   Slave channel: one message byte per transfer on s_axis_tdata, s_axis_tlast
//   marks the final byte. Every four bytes (or the final partial group) form a
//   big-endian word that is split into five base-85 digits, sent most
//   significant first as characters 33..117 on the master channel. A partial
//   group of n bytes is zero-padded and gives n+1 characters.
//   m_axis_tuser is high on the last character of a group, m_axis_tlast on the
//   last character of the message.
//   A group passes through the b85_pack register, the divider and the b85_serial
//   output register before its first character is valid. The divider is a 4-step,
//   8-register pipeline (reciprocal multiply, then remainder) that takes a group per
//   cycle unless the serializer stalls it. Throughput: one character per cycle on
//   the master side while the receiver is ready; bytes that only fill a group are
//   taken one per cycle while the pipeline has room.
//   Reset clears the held bytes and empties every stage. When the receiver
//   stalls, characters hold, the pipeline fills and s_axis_tready drops.
`default_nettype none

module base85_stream_encoder (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire          s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [7:0]   m_axis_tdata,   // [6:0] code_char, [7] zero
    output logic         m_axis_tuser,   // run_end
    output logic         m_axis_tlast    // message_end
);

    logic                 w_vld [5];
    logic                 w_rdy [5];
    b85_pkg::t_grp        w_grp [5];
    b85_pkg::t_digit      w_char;

    b85_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_axis_tvalid),
        .o_rdy   (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_vld   (w_vld[0]),
        .i_rdy   (w_rdy[0]),
        .o_grp   (w_grp[0])
    );

    for (genvar g = 0; g < 4; g++) begin : g_div
        b85_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .o_rdy   (w_rdy[g]),
            .i_grp   (w_grp[g]),
            .o_vld   (w_vld[g+1]),
            .i_rdy   (w_rdy[g+1]),
            .o_grp   (w_grp[g+1])
        );
    end

    b85_serial u_serial (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (w_vld[4]),
        .o_rdy     (w_rdy[4]),
        .i_grp     (w_grp[4]),
        .o_vld     (m_axis_tvalid),
        .i_rdy     (m_axis_tready),
        .o_char    (w_char),
        .o_run_end (m_axis_tuser),
        .o_msg_end (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_char};

endmodule

`default_nettype wire

@@ tb/base85_stream_encoder_test.sv @@
// base85_stream_encoder_test: self-checking bench for the streaming base-85 encoder.
// Depends on b85_pkg and base85_stream_encoder. Directed table first, then random
// messages, with random idle cycles on both channels.
`timescale 1ns / 1ps
`default_nettype none

module base85_stream_encoder_test;

    localparam int unsigned RADIX        = 85;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          RANDOM_ITEMS = 310;

    typedef logic [0:4][b85_pkg::DIGIT_W-1:0] t_chars;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       known;   // chars hold the typed-in group
        t_chars     chars;
    } t_row;

    typedef struct packed {
        logic [b85_pkg::DIGIT_W-1:0] code;
        logic                        run_end;
        logic                        msg_end;
    } t_char;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'h00;
    logic s_tlast = 1'b0;
    logic m_tready = 1'b0;
    wire  s_axis_tready;
    wire  m_axis_tvalid;
    wire  [7:0] m_axis_tdata;
    wire  m_axis_tuser;
    wire  m_axis_tlast;

    base85_stream_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),      // [7:0] data_byte
        .s_axis_tlast  (s_tlast),      // last_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata), // [6:0] code_char, [7] zero
        .m_axis_tuser  (m_axis_tuser), // run_end
        .m_axis_tlast  (m_axis_tlast)  // message_end
    );

    // encoder state mirror
    logic [23:0] held_word = '0;
    logic [1:0]  held_n = '0;

    t_char pending_chars[$];
    t_row  dir_rows[$];
    int    errors = 0;
    logic  tx_calm = 1'b0;
    logic  rx_calm = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    function automatic void cmp(string name, int unsigned expv, int unsigned actv);
        if (expv != actv) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
            errors++;
        end
    endfunction

    // Folds one byte into the held group; returns the characters it releases.
    task automatic b85_encode(input logic [7:0] b, input logic lst,
                              output int cnt, output t_chars chars);
        logic [31:0] word;
        logic [2:0]  n;
        int          i;
        n = {1'b0, held_n} + 3'd1;
        chars = '0;
        cnt = 0;
        if (!lst && n < 3'd4) begin
            held_word = {held_word[15:0], b};
            held_n = n[1:0];
        end else begin
            word = {held_word, b} << (8 * (4 - n));
            for (i = 4; i >= 0; i--) begin
                chars[i] = b85_pkg::t_digit'(word % RADIX) + b85_pkg::CHAR_OFFSET;
                word = word / RADIX;
            end
            cnt = n + 1;
            held_word = '0;
            held_n = '0;
        end
    endtask

    task automatic send_byte(input t_row row);
        int     gap;
        int     cnt;
        t_chars chars;
        t_char  c;
        if ($urandom_range(0, 24) == 0) begin
            tx_calm = ~tx_calm;
        end
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= row.data;
        s_tlast <= row.last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        b85_encode(row.data, row.last, cnt, chars);
        if (row.known) begin
            chars = row.chars;
        end
        for (int i = 0; i < cnt; i++) begin
            c.code = chars[i];
            c.run_end = (i == cnt - 1);
            c.msg_end = (i == cnt - 1) && row.last;
            pending_chars.push_back(c);
        end
    endtask

    task automatic add_row(input logic [7:0] data, input logic last,
                           input logic known, input t_chars chars);
        t_row r;
        r.data = data;
        r.last = last;
        r.known = known;
        r.chars = chars;
        dir_rows.push_back(r);
    endtask

    task automatic check_char();
        t_char e;
        if (pending_chars.size() == 0) begin
            $error("unexpected character 0x%0h", m_axis_tdata);
            errors++;
        end else begin
            e = pending_chars.pop_front();
            cmp("code_char", e.code, m_axis_tdata[6:0]);
            cmp("tdata[7]", 0, m_axis_tdata[7]);
            cmp("run_end", e.run_end, m_axis_tuser);
            cmp("message_end", e.msg_end, m_axis_tlast);
        end
    endtask

    // receiver: checks every transfer, stalls at random
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_tready) begin
                check_char();
            end
            if ($urandom_range(0, 99) == 0) begin
                rx_calm = ~rx_calm;
            end
            if (!i_rst_n) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 99) < 25) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        t_row r;
        int   sent;
        int   len;
        int   pick;
        t_chars none;
        none = '0;

        // lone zero byte, zero group, all-ones group: readable by eye
        add_row(8'h00, 1'b1, 1'b1, {7'd33, 7'd33, 7'd0, 7'd0, 7'd0});
        add_row(8'h00, 1'b0, 1'b0, none);
        add_row(8'h00, 1'b0, 1'b0, none);
        add_row(8'h00, 1'b0, 1'b0, none);
        add_row(8'h00, 1'b0, 1'b1, {7'd33, 7'd33, 7'd33, 7'd33, 7'd33});
        add_row(8'hFF, 1'b0, 1'b0, none);
        add_row(8'hFF, 1'b0, 1'b0, none);
        add_row(8'hFF, 1'b0, 1'b0, none);
        add_row(8'hFF, 1'b0, 1'b1, {7'd115, 7'd56, 7'd87, 7'd45, 7'd33});
        // partial groups of two and three bytes, a full final group, then groups of one and three bytes
        add_row(8'hFF, 1'b0, 1'b0, none);
        add_row(8'hFF, 1'b1, 1'b0, none);
        add_row(8'h80, 1'b0, 1'b0, none);
        add_row(8'h01, 1'b0, 1'b0, none);
        add_row(8'h7F, 1'b1, 1'b0, none);
        add_row(8'h12, 1'b0, 1'b0, none);
        add_row(8'h34, 1'b0, 1'b0, none);
        add_row(8'h56, 1'b0, 1'b0, none);
        add_row(8'h78, 1'b1, 1'b0, none);
        add_row(8'hFF, 1'b1, 1'b0, none);
        add_row(8'h00, 1'b0, 1'b0, none);
        add_row(8'hFF, 1'b0, 1'b0, none);
        add_row(8'h00, 1'b1, 1'b0, none);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i]);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = $urandom_range(1, 8);
            end else if (pick < 95) begin
                len = $urandom_range(9, 20);
            end else begin
                len = $urandom_range(21, 40);
            end
            for (int i = 0; i < len; i++) begin
                pick = $urandom_range(0, 9);
                r.data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
                r.last = (i == len - 1);
                r.known = 1'b0;
                r.chars = '0;
                send_byte(r);
            end
            sent += len;
        end
        s_tvalid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_chars.size() != 0) begin
            $error("%0d characters never arrived", pending_chars.size());
            errors++;
        end
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
